// File: hdl/mmid_pkg.sv
// ----------------------------------------------------------------------------
// mmid_pkg - shared types and constants of the mask/value instruction decoder
// Holds the 38-entry class table, the operand-use flags and the decode
// result type that travels from the classifier to the result register.
// ----------------------------------------------------------------------------
package mmid_pkg;

    localparam int NUM_CLASSES = 38;
    localparam int WORD_W      = 16;
    localparam int CLASS_W     = 6;
    localparam int ADDR_W      = 12;
    localparam int INDEX_W     = ADDR_W - 1;
    localparam int REG_W       = 3;
    localparam int IMM_W       = 8;
    localparam int TGT_W       = 12;

    // Operand-use flags, one bit per field source
    localparam logic [7:0] USE_NONE = 8'h00;
    localparam logic [7:0] USE_DST  = 8'h01;
    localparam logic [7:0] USE_S1   = 8'h02;
    localparam logic [7:0] USE_S2   = 8'h04;
    localparam logic [7:0] USE_IMM  = 8'h08;
    localparam logic [7:0] USE_TGT  = 8'h10;
    localparam logic [7:0] USE_PID  = 8'h20;
    localparam logic [7:0] USE_S1HI = 8'h40;
    localparam logic [7:0] USE_S1TP = 8'h80;

    localparam logic [7:0] USE_ALU3 = USE_DST | USE_S1 | USE_S2;

    typedef struct packed {
        logic [WORD_W-1:0] mask;
        logic [WORD_W-1:0] value;
        logic [7:0]        uses;
    } class_entry_t;

    // Classes in priority order: the first entry that matches wins
    localparam class_entry_t CLASS_TABLE [NUM_CLASSES] = '{
        '{16'hF000, 16'h0000, USE_TGT},            // jmp
        '{16'hF000, 16'h1000, USE_TGT},            // call
        '{16'hF000, 16'h2000, USE_TGT},            // bltu
        '{16'hF000, 16'h3000, USE_TGT},            // bleu
        '{16'hF000, 16'h4000, USE_TGT},            // blts
        '{16'hF000, 16'h5000, USE_TGT},            // bles
        '{16'hF000, 16'h6000, USE_TGT},            // beq
        '{16'hF000, 16'h7000, USE_TGT},            // bne
        '{16'hFFFF, 16'h9003, USE_NONE},           // nop
        '{16'hFFFF, 16'h9007, USE_NONE},           // halt
        '{16'hFFFF, 16'h900B, USE_NONE},           // ret
        '{16'hFFFF, 16'h900F, USE_NONE},           // enzr
        '{16'hFFFF, 16'h9013, USE_NONE},           // dszr
        '{16'hFF1F, 16'h9000, USE_S1},             // push
        '{16'hFF1F, 16'h9004, USE_S1},             // wrss
        '{16'hFF1F, 16'h9008, USE_S1},             // wrds
        '{16'hFF1F, 16'h900C, USE_S1},             // wrsp
        '{16'hF8FF, 16'h9001, USE_DST},            // pop
        '{16'hF8FF, 16'h9005, USE_DST},            // rdss
        '{16'hF8FF, 16'h9009, USE_DST},            // rdds
        '{16'hF8FF, 16'h900D, USE_DST},            // rdsp
        '{16'hFF03, 16'h9800, USE_S1 | USE_PID},   // out
        '{16'hF8E3, 16'h9801, USE_DST | USE_PID},  // in
        '{16'hF81F, 16'h9002, USE_DST | USE_S1},   // mov
        '{16'hF81F, 16'h9006, USE_DST | USE_S1},   // not
        '{16'hF81F, 16'h900A, USE_DST | USE_S1},   // ldr
        '{16'hF81F, 16'h900E, USE_DST | USE_S1},   // str
        '{16'hF803, 16'h8000, USE_ALU3},           // add
        '{16'hF803, 16'h8001, USE_ALU3},           // sub
        '{16'hF803, 16'h8002, USE_ALU3},           // adc
        '{16'hF803, 16'h8003, USE_ALU3},           // sbc
        '{16'hF803, 16'h8800, USE_ALU3},           // and
        '{16'hF803, 16'h8801, USE_ALU3},           // or
        '{16'hF803, 16'h8802, USE_ALU3},           // xor
        '{16'hF800, 16'hA000, USE_DST | USE_IMM},  // ldi
        '{16'hF800, 16'hA800, USE_DST | USE_IMM},  // srldr
        '{16'hF800, 16'hB000, USE_S1HI | USE_IMM}, // srstr
        '{16'hC000, 16'hC000, USE_DST | USE_S1TP | USE_IMM} // addi
    };

    typedef struct packed {
        logic [ADDR_W-1:0]  byte_address;
        logic               found;
        logic [CLASS_W-1:0] class_index;
        logic [REG_W-1:0]   dest_reg;
        logic [REG_W-1:0]   first_source;
        logic [REG_W-1:0]   second_source;
        logic [IMM_W-1:0]   imm_byte;
        logic [TGT_W-1:0]   jump_target;
        logic [REG_W-1:0]   port_id;
    } dec_result_t;

endpackage

// File: hdl/mask_match_instruction_decoder_unit.sv
// ----------------------------------------------------------------------------
// mask_match_instruction_decoder_unit - 16-bit instruction word decoder
// Input register, table classifier and result register with a word counter.
// ----------------------------------------------------------------------------
// Usage:
//   The s_ channel takes one instruction word per beat; the m_ channel returns
//   one decode beat per word, in order: byte address, found flag, class index
//   and the operand fields of the matched class (unused fields are zero).
//   A word accepted on s_ is captured in the input register, decoded, and
//   then captured in the result register, which drives m_.
//   Throughput is one word per cycle while m_ready is high, set by the single
//   pass of mask compares between the input register and the result register.
//   The byte address counts accepted words times two and wraps at 4096.
//   A synchronous low aresetn empties both registers and clears the counter.
//   When m_ready is low, the result register holds; the input register still
//   takes one more word, and s_ready then drops until the result drains.
// ----------------------------------------------------------------------------
module mask_match_instruction_decoder_unit
    import mmid_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [WORD_W-1:0]   s_instr_word,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [ADDR_W-1:0]   m_byte_address,
    output logic                m_found,
    output logic [CLASS_W-1:0]  m_class_index,
    output logic [REG_W-1:0]    m_dest_reg,
    output logic [REG_W-1:0]    m_first_source,
    output logic [REG_W-1:0]    m_second_source,
    output logic [IMM_W-1:0]    m_imm_byte,
    output logic [TGT_W-1:0]    m_jump_target,
    output logic [REG_W-1:0]    m_port_id
);

    logic               in_valid_reg;
    logic [WORD_W-1:0]  in_word_reg;
    logic [ADDR_W-1:0]  in_addr_reg;
    logic [INDEX_W-1:0] word_index_reg;
    logic [INDEX_W-1:0] word_index_next;
    logic               out_valid_reg;
    dec_result_t        out_reg;
    dec_result_t        dec_next;
    logic               out_load;
    logic               in_load;

    // Advance each stage when the stage after it has room
    assign out_load        = !out_valid_reg || m_ready;
    assign s_ready         = !in_valid_reg || out_load;
    assign in_load         = s_valid && s_ready;
    assign word_index_next = word_index_reg + INDEX_W'(1);

    // Input register and word counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            word_index_reg <= '0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (in_load) begin
                word_index_reg <= word_index_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_load) begin
            in_word_reg <= s_instr_word;
            in_addr_reg <= {word_index_reg, 1'b0};
        end
    end

    mmid_classify u_classify (
        .word         (in_word_reg),
        .byte_address (in_addr_reg),
        .result       (dec_next)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load && in_valid_reg) begin
            out_reg <= dec_next;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_byte_address  = out_reg.byte_address;
    assign m_found         = out_reg.found;
    assign m_class_index   = out_reg.class_index;
    assign m_dest_reg      = out_reg.dest_reg;
    assign m_first_source  = out_reg.first_source;
    assign m_second_source = out_reg.second_source;
    assign m_imm_byte      = out_reg.imm_byte;
    assign m_jump_target   = out_reg.jump_target;
    assign m_port_id       = out_reg.port_id;

endmodule

// File: hdl/mmid_classify.sv
// ----------------------------------------------------------------------------
// mmid_classify - table match and operand extraction
// Compares one word against every class entry in parallel, picks the first
// hit in table order and gates each operand field by the class's use flags.
// ----------------------------------------------------------------------------
module mmid_classify
    import mmid_pkg::*;
(
    input  logic [WORD_W-1:0] word,
    input  logic [ADDR_W-1:0] byte_address,
    output dec_result_t       result
);

    logic               hit;
    logic [CLASS_W-1:0] hit_index;
    logic [7:0]         uses;

    // Scan from the last entry down so the lowest matching index wins
    always_comb begin
        hit       = 1'b0;
        hit_index = '0;
        uses      = USE_NONE;
        for (int k = NUM_CLASSES - 1; k >= 0; k--) begin
            if ((word & CLASS_TABLE[k].mask) == CLASS_TABLE[k].value) begin
                hit       = 1'b1;
                hit_index = CLASS_W'(k);
                uses      = CLASS_TABLE[k].uses;
            end
        end
    end

    // Gate operand fields; unused fields read as zero
    always_comb begin
        result               = '0;
        result.byte_address  = byte_address;
        result.found         = hit;
        result.class_index   = hit_index;
        if ((uses & USE_DST) != USE_NONE) begin
            result.dest_reg = word[10:8];
        end
        if ((uses & USE_S1) != USE_NONE) begin
            result.first_source = word[7:5];
        end
        if ((uses & USE_S1HI) != USE_NONE) begin
            result.first_source = word[10:8];
        end
        if ((uses & USE_S1TP) != USE_NONE) begin
            result.first_source = word[13:11];
        end
        if ((uses & USE_S2) != USE_NONE) begin
            result.second_source = word[4:2];
        end
        if ((uses & USE_IMM) != USE_NONE) begin
            result.imm_byte = word[7:0];
        end
        if ((uses & USE_TGT) != USE_NONE) begin
            result.jump_target = word[11:0];
        end
        if ((uses & USE_PID) != USE_NONE) begin
            result.port_id = word[4:2];
        end
    end

endmodule

// File: hdl/mmid_checker.sv
// ----------------------------------------------------------------------------
// mmid_checker - port-level checks of the instruction decoder
// Watches the top level's ports and flags decode beats that break the
// block's rules on stalls, unknown words, unused fields, index range and reset.
// ----------------------------------------------------------------------------
module mmid_checker
    import mmid_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                m_valid,
    input logic                m_ready,
    input logic [ADDR_W-1:0]   m_byte_address,
    input logic                m_found,
    input logic [CLASS_W-1:0]  m_class_index,
    input logic [REG_W-1:0]    m_dest_reg,
    input logic [REG_W-1:0]    m_first_source,
    input logic [REG_W-1:0]    m_second_source,
    input logic [IMM_W-1:0]    m_imm_byte,
    input logic [TGT_W-1:0]    m_jump_target,
    input logic [REG_W-1:0]    m_port_id
);

    // Hold a stalled beat unchanged
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_byte_address)
            && $stable(m_class_index) && $stable(m_found))
        else $error("stalled decode beat changed");

    // Drop the class index and all operand fields for an unknown word
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_found |-> m_class_index == '0 && m_dest_reg == '0
            && m_first_source == '0 && m_second_source == '0 && m_imm_byte == '0
            && m_jump_target == '0 && m_port_id == '0)
        else $error("unknown word carries operand fields");

    // Branch classes carry only a target
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_found && m_class_index < CLASS_W'(8) |-> m_dest_reg == '0
            && m_first_source == '0 && m_imm_byte == '0 && m_port_id == '0)
        else $error("branch class carries register fields");

    // Matched index stays inside the table and the byte address stays even
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_class_index < CLASS_W'(NUM_CLASSES) && !m_byte_address[0])
        else $error("class index or byte address out of range");

    // Reset empties the result side
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

bind mask_match_instruction_decoder_unit mmid_checker u_mmid_checker (.*);
